>>> hw/rtl/mtes_pkg.sv
// ----------------------------------------------------------------------------
// mtes_pkg: shared types and constants of the timer scheduler
// Command and status codes, field widths and the row control word.
// ----------------------------------------------------------------------------
package mtes_pkg;

  localparam int NUM_TIMERS_DEF = 16;
  localparam int TIME_BITS_DEF  = 32;
  localparam int IN_W           = 32;
  localparam int SLOT_W         = 4;
  localparam int TAG_W          = 16;
  localparam int CNT_W          = 16;
  localparam int STAT_W         = 3;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_CREATE = 2'd1,
    CMD_DELETE = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_NONE    = 3'd0,
    ST_EXPIRY  = 3'd1,
    ST_CREATED = 3'd2,
    ST_FULL    = 3'd3,
    ST_DELETED = 3'd4,
    ST_UNUSED  = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SWEEP,
    S_DIV,
    S_DONE
  } state_t;

  // control word handed to every cell of the row
  typedef struct packed {
    logic shift;    // rotate the row by one cell
    logic reload;   // reload or free the selected cell after an expiry
  } row_ctl_t;

endpackage

>>> hw/rtl/mtes_cell.sv
// ----------------------------------------------------------------------------
// mtes_cell: one timer slot of the rotating row
// Holds live mark, remaining time, period, one-shot mark and tag.
// ----------------------------------------------------------------------------
module mtes_cell
  import mtes_pkg::*;
#(
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  row_ctl_t              ctl,
  input  logic                  sel,
  input  logic                  in_live,
  input  logic [TIME_BITS+1:0]  in_rem,
  input  logic [TIME_BITS-1:0]  in_per,
  input  logic                  in_shot,
  input  logic [TAG_W-1:0]      in_tag,
  output logic                  live,
  output logic [TIME_BITS+1:0]  rem,
  output logic [TIME_BITS-1:0]  per,
  output logic                  shot,
  output logic [TAG_W-1:0]      tag
);

  always_ff @(posedge clk) begin
    if (rst) begin
      live <= 1'b0;
    end else if (ctl.shift) begin
      live <= in_live;
    end else if (ctl.reload && sel && shot) begin
      live <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      rem  <= in_rem;
      per  <= in_per;
      shot <= in_shot;
      tag  <= in_tag;
    end else if (ctl.reload && sel) begin
      rem  <= {2'b00, per};
    end
  end

endmodule

>>> hw/rtl/mtes_divider.sv
// ----------------------------------------------------------------------------
// mtes_divider: restoring divider for the overrun count
// One quotient bit a cycle, saturating the quotient at its maximum.
// ----------------------------------------------------------------------------
module mtes_divider
  import mtes_pkg::*;
#(
  parameter int NW = 34
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             go,
  input  logic [NW-1:0]    num,
  input  logic [NW-1:0]    den,
  output logic             done,
  output logic [CNT_W-1:0] quo
);

  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] n, d, q;
  logic [NW:0]   r;
  logic [CW-1:0] cnt;
  logic          run;
  logic [NW:0]   trial;

  assign trial = {r[NW-1:0], n[NW-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= CW'(NW);
        n   <= num;
        d   <= den;
        r   <= '0;
        q   <= '0;
      end else if (run) begin
        n <= {n[NW-2:0], 1'b0};
        if (trial >= {1'b0, d}) begin
          r <= trial - {1'b0, d};
          q <= {q[NW-2:0], 1'b1};
        end else begin
          r <= trial;
          q <= {q[NW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // saturate at the count limit
  assign quo = (q > NW'({CNT_W{1'b1}})) ? {CNT_W{1'b1}} : q[CNT_W-1:0];

endmodule

>>> hw/rtl/multi_timer_expiry_scheduler.sv
// ----------------------------------------------------------------------------
// multi_timer_expiry_scheduler: table of periodic and one-shot timers
// Rotating row of timer cells swept once per command.
// ----------------------------------------------------------------------------
// create and delete strobe their result word as the sweep ends, after one full turn of the row;
//   a tick strobes it from the S_DONE state after the turn; an expiry adds a divider run in S_DIV
// a new command is taken only in S_IDLE; busy is high from start until the state returns there
// the result strobe lasts one cycle; the receiver cannot stall
// reset clears all live marks at once; no clearing pass is needed
module multi_timer_expiry_scheduler
  import mtes_pkg::*;
#(
  parameter int NUM_TIMERS = NUM_TIMERS_DEF,
  parameter int TIME_BITS  = TIME_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        command,
  input  logic [IN_W-1:0]   elapsed_ticks,
  input  logic [IN_W-1:0]   duration_ticks,
  input  logic              one_shot,
  input  logic [TAG_W-1:0]  target_tag,
  input  logic [SLOT_W-1:0] slot_handle,
  output logic              done,
  output logic [STAT_W-1:0] status,
  output logic [SLOT_W-1:0] timer_slot,
  output logic [TAG_W-1:0]  expired_tag,
  output logic [CNT_W-1:0]  overrun_count
);

  localparam int RW  = TIME_BITS + 2;
  localparam int IW  = (TIME_BITS < IN_W) ? TIME_BITS : IN_W;
  localparam int PW  = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int CW  = $clog2(NUM_TIMERS + 1);
  localparam logic signed [RW-1:0] NEG_LIM = {2'b10, {TIME_BITS{1'b0}}};

  state_t state, state_next;
  cmd_t   cmd;
  logic [CW-1:0] pos;
  logic [IW-1:0] elap, dur;
  logic          shot_in;
  logic [TAG_W-1:0] tag_in;
  logic [SLOT_W-1:0] hnd;
  logic          found, have_best;
  logic [PW-1:0] best_pos;
  logic signed [RW-1:0] best_rem;
  logic [TIME_BITS-1:0] best_per;
  logic          best_shot;
  logic [TAG_W-1:0] best_tag;
  logic          div_go, div_done;
  logic [CNT_W-1:0] div_q;
  logic          last;
  logic          exp_wr;

  row_ctl_t ctl;
  logic                 c_live [NUM_TIMERS];
  logic [RW-1:0]        c_rem  [NUM_TIMERS];
  logic [TIME_BITS-1:0] c_per  [NUM_TIMERS];
  logic                 c_shot [NUM_TIMERS];
  logic [TAG_W-1:0]     c_tag  [NUM_TIMERS];

  // head of the row is cell 0; its word is modified and fed into the tail
  logic                 h_live;
  logic [RW-1:0]        h_rem;
  logic signed [RW:0]   diff;

  assign last = (pos == CW'(NUM_TIMERS - 1));

  always_comb begin
    h_live = c_live[0];
    h_rem  = c_rem[0];
    diff   = $signed({c_rem[0][RW-1], c_rem[0]}) - $signed({{(RW+1-IW){1'b0}}, elap});
    case (cmd)
      CMD_TICK: begin
        if (c_live[0]) begin
          h_rem = (diff < $signed({NEG_LIM[RW-1], NEG_LIM})) ? NEG_LIM : diff[RW-1:0];
        end
      end
      CMD_CREATE: begin
        if (!c_live[0] && !found) begin
          h_live = 1'b1;
          h_rem  = RW'(dur);
        end
      end
      CMD_DELETE: begin
        if (SLOT_W'(pos) == hnd && 32'(hnd) < NUM_TIMERS) begin
          h_live = 1'b0;
        end
      end
      default: ;
    endcase
  end

  assign ctl.shift  = (state == S_SWEEP);
  assign ctl.reload = exp_wr;

  for (genvar g = 0; g < NUM_TIMERS; g++) begin : g_cell
    localparam int NX = (g + 1) % NUM_TIMERS;
    logic                 i_live, i_shot;
    logic [RW-1:0]        i_rem;
    logic [TIME_BITS-1:0] i_per;
    logic [TAG_W-1:0]     i_tag;
    if (g == NUM_TIMERS - 1) begin : g_tail
      logic wr;
      assign wr     = (cmd == CMD_CREATE) && !c_live[0] && !found;
      assign i_live = h_live;
      assign i_rem  = h_rem;
      assign i_per  = wr ? TIME_BITS'(dur) : c_per[0];
      assign i_shot = wr ? shot_in : c_shot[0];
      assign i_tag  = wr ? tag_in : c_tag[0];
    end else begin : g_mid
      assign i_live = c_live[NX];
      assign i_rem  = c_rem[NX];
      assign i_per  = c_per[NX];
      assign i_shot = c_shot[NX];
      assign i_tag  = c_tag[NX];
    end
    mtes_cell #(.TIME_BITS(TIME_BITS)) u_cell (
      .clk(clk), .rst(rst), .ctl(ctl), .sel(best_pos == PW'(g)),
      .in_live(i_live), .in_rem(i_rem), .in_per(i_per),
      .in_shot(i_shot), .in_tag(i_tag),
      .live(c_live[g]), .rem(c_rem[g]), .per(c_per[g]),
      .shot(c_shot[g]), .tag(c_tag[g])
    );
  end

  mtes_divider #(.NW(RW)) u_div (
    .clk(clk), .rst(rst), .go(div_go),
    .num(RW'(best_per) - best_rem),
    .den(RW'(best_per)),
    .done(div_done), .quo(div_q)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (start) state_next = S_SWEEP;
      S_SWEEP: if (last) state_next = S_DONE;
      S_DONE: begin
        if (cmd == CMD_TICK && have_best && best_rem <= 0) state_next = S_DIV;
        else state_next = S_IDLE;
      end
      S_DIV:   if (div_done) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy   = (state != S_IDLE);
    div_go = (state == S_DONE) && (cmd == CMD_TICK) && have_best && (best_rem <= 0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // the row is back home after the sweep, so the expired cell is reloaded in place
  assign exp_wr = (state == S_DIV) && div_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (state == S_SWEEP && last && cmd != CMD_TICK) done <= 1'b1;
      if (state == S_DONE && !div_go && cmd == CMD_TICK) done <= 1'b1;
      if (exp_wr) done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      cmd       <= cmd_t'(command);
      elap      <= elapsed_ticks[IW-1:0];
      dur       <= (duration_ticks[IW-1:0] == '0) ? IW'(1) : duration_ticks[IW-1:0];
      shot_in   <= one_shot;
      tag_in    <= target_tag;
      hnd       <= slot_handle;
      pos       <= '0;
      found     <= 1'b0;
      have_best <= 1'b0;
    end else if (state == S_SWEEP) begin
      pos <= pos + 1'b1;
      if (cmd == CMD_CREATE && !c_live[0] && !found) begin
        found    <= 1'b1;
        best_pos <= PW'(pos);
      end
      // delete hit remembered, the head word has gone back round by the end
      if (cmd == CMD_DELETE && c_live[0] && SLOT_W'(pos) == hnd &&
          32'(hnd) < NUM_TIMERS) begin
        found <= 1'b1;
      end
      if (cmd == CMD_TICK && c_live[0] &&
          (!have_best || $signed(h_rem) < best_rem)) begin
        have_best <= 1'b1;
        best_pos  <= PW'(pos);
        best_rem  <= h_rem;
        best_per  <= c_per[0];
        best_shot <= c_shot[0];
        best_tag  <= c_tag[0];
      end
    end
  end

  // result word
  always_ff @(posedge clk) begin
    if (state == S_SWEEP && last) begin
      status        <= ST_NONE;
      timer_slot    <= '0;
      expired_tag   <= '0;
      overrun_count <= '0;
      case (cmd)
        CMD_CREATE: begin
          if (found || !c_live[0]) begin
            status     <= ST_CREATED;
            timer_slot <= found ? SLOT_W'(best_pos) : SLOT_W'(pos);
          end else begin
            status <= ST_FULL;
          end
        end
        CMD_DELETE: begin
          timer_slot <= hnd;
          status <= (found || (c_live[0] && SLOT_W'(pos) == hnd &&
                     32'(hnd) < NUM_TIMERS)) ? ST_DELETED : ST_UNUSED;
        end
        default: ;
      endcase
    end else if (exp_wr) begin
      status        <= ST_EXPIRY;
      timer_slot    <= SLOT_W'(best_pos);
      expired_tag   <= best_tag;
      overrun_count <= div_q;
    end
  end

  // one strobe per command, never high back to back
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done);
  a_busy_taken: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy);
  a_div_tick: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (cmd == CMD_TICK));

endmodule
